>>> rtl/tcdr_pkg.sv
// types, constants and calendar helper functions shared by the tick calendar block
package tcdr_pkg;

  // operation codes carried in the mode field
  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_RESOLVE = 2'd1;
  localparam logic [1:0] MODE_RATE    = 2'd2;

  // rate limits: day length is seconds times ticks per second
  localparam logic [10:0] MAX_SECONDS   = 11'd1365;
  localparam logic [14:0] MAX_TICKS_S16 = 15'd32767;

  // restoring divider runs over the full width of counter times day length
  localparam int unsigned DIV_BITS = 30;

  // shared unit operand width
  localparam int unsigned ALU_W = 17;

  // reset date
  localparam logic [3:0] RESET_MONTH = 4'd2;
  localparam logic [4:0] RESET_DAY   = 5'd17;

  localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // reciprocal of 100 scaled by 2^23, rounded up
  localparam logic [16:0] RECIP_100 = 17'd83887;

  typedef struct packed {
    logic [1:0]  mode;
    logic        is_relative;
    logic [7:0]  month_field;
    logic [9:0]  day_field;
    logic [15:0] year_field;
    logic [10:0] day_seconds;
  } in_item_t;

  typedef struct packed {
    logic               rolled_over;
    logic [7:0]         out_month;
    logic [9:0]         out_day;
    logic [15:0]        out_year;
    logic               not_past;
    logic signed [15:0] ticks_left;
  } out_item_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             cout;
  } alu_rsp_t;

  // gregorian leap year; y/100 taken by reciprocal multiply, exact for 16-bit y
  function automatic logic is_leap(input logic [15:0] y);
    logic [32:0] p;
    logic        mult100;
    p       = {17'd0, y} * {16'd0, RECIP_100};
    mult100 = (p[22:16] == 7'd0);
    return (y[1:0] == 2'd0) && (!mult100 || (p[24:23] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [3:0] idx;
    idx = m - 4'd1;
    if ((m == 4'd0) || (m > MONTHS_PER_YEAR)) begin
      return 5'd31;
    end else if ((m == 4'd2) && leap) begin
      return 5'd29;
    end else begin
      return MONTH_DAYS[idx];
    end
  endfunction

endpackage

>>> rtl/tick_calendar_with_date_resolve_top.sv
// tick calendar: tick counter, gregorian day roll, relative date resolve, rate rescale
// a rate change against a running counter rescales it in 30 restoring divide steps
// relative resolve steps through the month sum, then the day offset a month at a time
// throughput: one transaction at a time; the next is taken once the previous reaches the
// output register, which holds a result while the consumer stalls
// reset (synchronous, rst_n low): counter 0, day length 0 (halted), date 17 feb EPOCH_YEAR
module tick_calendar_with_date_resolve_top #(
  parameter logic [15:0] EPOCH_YEAR = 16'd2155
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcdr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tcdr_pkg::out_item_t out_data
);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TICK  = 4'd1;
  localparam logic [3:0] S_LEAP  = 4'd2;
  localparam logic [3:0] S_TADV  = 4'd3;
  localparam logic [3:0] S_MDIV  = 4'd4;
  localparam logic [3:0] S_DLOOP = 4'd5;
  localparam logic [3:0] S_RATE1 = 4'd6;
  localparam logic [3:0] S_RATE2 = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_RFIN  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  // control and architectural state
  logic [3:0]         state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] cnt_r, cnt_nxt;
  logic [14:0]        day_len_r, day_len_nxt;
  logic [3:0]         cur_month_r, cur_month_nxt;
  logic [4:0]         cur_day_r, cur_day_nxt;
  logic [15:0]        cur_year_r, cur_year_nxt;

  // working registers of the current transaction
  logic [1:0]                     mode_r, mode_nxt;
  logic                           rolled_r, rolled_nxt;
  logic [8:0]                     wm_r, wm_nxt;
  logic [10:0]                    wd_r, wd_nxt;
  logic [15:0]                    wy_r, wy_nxt;
  logic                           leap_r, leap_nxt;
  logic [10:0]                    secs_r, secs_nxt;
  logic [14:0]                    nd_r, nd_nxt;
  logic [tcdr_pkg::DIV_BITS-1:0]  dq_r, dq_nxt;
  logic [15:0]                    rem_r, rem_nxt;
  logic [4:0]                     bit_cnt_r, bit_cnt_nxt;
  tcdr_pkg::out_item_t            out_data_r, out_data_nxt;

  tcdr_pkg::alu_req_t alu_req;
  tcdr_pkg::alu_rsp_t alu_rsp;

  logic [4:0]         mlen;
  logic signed [15:0] dec;
  logic [16:0]        div_shift;
  logic               not_past;

  tcdr_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // length of the working month, leap flag taken from the registered year check
  assign mlen      = tcdr_pkg::month_len(wm_r[3:0], leap_r);
  assign dec       = signed'(alu_rsp.res[15:0]);
  assign div_shift = {rem_r, dq_r[tcdr_pkg::DIV_BITS-1]};

  // resolved date against the current date, year then month then day
  assign not_past = (wy_r > cur_year_r)
                 || ((wy_r == cur_year_r) && ((wm_r > {5'd0, cur_month_r})
                 || ((wm_r == {5'd0, cur_month_r}) && (wd_r >= {6'd0, cur_day_r}))));

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    day_len_nxt   = day_len_r;
    cur_month_nxt = cur_month_r;
    cur_day_nxt   = cur_day_r;
    cur_year_nxt  = cur_year_r;
    mode_nxt      = mode_r;
    rolled_nxt    = rolled_r;
    wm_nxt        = wm_r;
    wd_nxt        = wd_r;
    wy_nxt        = wy_r;
    leap_nxt      = leap_r;
    secs_nxt      = secs_r;
    nd_nxt        = nd_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_data_nxt  = out_data_r;
    alu_req.sub   = 1'b1;
    alu_req.a     = '0;
    alu_req.b     = '0;

    // consumer took the waiting result
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && rst_n) begin
          mode_nxt   = in_data.mode;
          rolled_nxt = 1'b0;
          unique case (in_data.mode)
            tcdr_pkg::MODE_TICK: begin
              state_nxt = S_TICK;
            end
            tcdr_pkg::MODE_RESOLVE: begin
              if (in_data.is_relative) begin
                // month offset folded onto the current month, zero based for the mod 12 pass
                wm_nxt    = {1'b0, in_data.month_field} + {5'd0, cur_month_r} - 9'd1;
                wd_nxt    = {1'b0, in_data.day_field} + {6'd0, cur_day_r};
                wy_nxt    = in_data.year_field + cur_year_r;
                state_nxt = S_MDIV;
              end else begin
                wm_nxt    = {1'b0, in_data.month_field};
                wd_nxt    = {1'b0, in_data.day_field};
                wy_nxt    = in_data.year_field;
                state_nxt = S_DONE;
              end
            end
            tcdr_pkg::MODE_RATE: begin
              secs_nxt  = (in_data.day_seconds > tcdr_pkg::MAX_SECONDS)
                        ? tcdr_pkg::MAX_SECONDS : in_data.day_seconds;
              state_nxt = S_RATE1;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_TICK: begin
        alu_req.a = {1'b0, cnt_r};
        alu_req.b = 17'd1;
        if (dec[15] || (dec == 16'sd0)) begin
          // counter expired: reload, and roll the day unless the clock is halted
          cnt_nxt = signed'({1'b0, day_len_r});
          if (day_len_r != 15'd0) begin
            rolled_nxt = 1'b1;
            wy_nxt     = cur_year_r;
            wm_nxt     = {5'd0, cur_month_r};
            wd_nxt     = {6'd0, cur_day_r} + 11'd1;
            state_nxt  = S_LEAP;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cnt_nxt   = dec;
          state_nxt = S_DONE;
        end
      end

      S_LEAP: begin
        leap_nxt  = tcdr_pkg::is_leap(wy_r);
        state_nxt = (mode_r == tcdr_pkg::MODE_TICK) ? S_TADV : S_DLOOP;
      end

      S_TADV: begin
        if (wd_r > {6'd0, mlen}) begin
          cur_day_nxt = 5'd1;
          if (wm_r[3:0] == tcdr_pkg::MONTHS_PER_YEAR) begin
            cur_month_nxt = 4'd1;
            cur_year_nxt  = wy_r + 16'd1;
          end else begin
            cur_month_nxt = wm_r[3:0] + 4'd1;
            cur_year_nxt  = wy_r;
          end
        end else begin
          cur_day_nxt   = wd_r[4:0];
          cur_month_nxt = wm_r[3:0];
          cur_year_nxt  = wy_r;
        end
        state_nxt = S_DONE;
      end

      S_MDIV: begin
        // whole years out of the month sum, one subtraction of 12 a cycle
        alu_req.a = {8'd0, wm_r};
        alu_req.b = {13'd0, tcdr_pkg::MONTHS_PER_YEAR};
        if (alu_rsp.cout) begin
          wm_nxt = alu_rsp.res[8:0];
          wy_nxt = wy_r + 16'd1;
        end else begin
          wm_nxt    = wm_r + 9'd1;
          state_nxt = S_LEAP;
        end
      end

      S_DLOOP: begin
        // strip one month length from the day while the day overruns it
        alu_req.a = {6'd0, wd_r};
        alu_req.b = {12'd0, mlen};
        if (alu_rsp.cout && (alu_rsp.res != 17'd0)) begin
          wd_nxt = alu_rsp.res[10:0];
          if (wm_r == {5'd0, tcdr_pkg::MONTHS_PER_YEAR}) begin
            wm_nxt    = 9'd1;
            wy_nxt    = wy_r + 16'd1;
            state_nxt = S_LEAP;
          end else begin
            wm_nxt = wm_r + 9'd1;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RATE1: begin
        // seconds times 24 as two shifted terms
        nd_nxt    = {secs_r, 4'd0} + {1'b0, secs_r, 3'd0};
        state_nxt = S_RATE2;
      end

      S_RATE2: begin
        if (day_len_r == 15'd0) begin
          cnt_nxt     = signed'({1'b0, nd_r});
          day_len_nxt = nd_r;
          state_nxt   = S_DONE;
        end else if (cnt_r[15] || (cnt_r == 16'sd0)) begin
          cnt_nxt     = 16'sd0;
          day_len_nxt = nd_r;
          state_nxt   = S_DONE;
        end else begin
          dq_nxt      = {15'd0, cnt_r[14:0]} * {15'd0, nd_r};
          rem_nxt     = 16'd0;
          bit_cnt_nxt = 5'd0;
          state_nxt   = S_DIV;
        end
      end

      S_DIV: begin
        // restoring divide by the old day length, quotient shifts in behind the dividend
        alu_req.a   = div_shift;
        alu_req.b   = {2'd0, day_len_r};
        rem_nxt     = alu_rsp.cout ? alu_rsp.res[15:0] : div_shift[15:0];
        dq_nxt      = {dq_r[tcdr_pkg::DIV_BITS-2:0], alu_rsp.cout};
        bit_cnt_nxt = bit_cnt_r + 5'd1;
        if (bit_cnt_r == 5'(tcdr_pkg::DIV_BITS - 1)) begin
          state_nxt = S_RFIN;
        end
      end

      S_RFIN: begin
        // at least one tick left, clamped to the signed counter range
        if (dq_r == '0) begin
          cnt_nxt = 16'sd1;
        end else if (dq_r[tcdr_pkg::DIV_BITS-1:15] != '0) begin
          cnt_nxt = signed'({1'b0, tcdr_pkg::MAX_TICKS_S16});
        end else begin
          cnt_nxt = signed'({1'b0, dq_r[14:0]});
        end
        day_len_nxt = nd_r;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.rolled_over = rolled_r;
          out_data_nxt.ticks_left  = cnt_r;
          if (mode_r == tcdr_pkg::MODE_RESOLVE) begin
            out_data_nxt.out_month = wm_r[7:0];
            out_data_nxt.out_day   = wd_r[9:0];
            out_data_nxt.out_year  = wy_r;
            out_data_nxt.not_past  = not_past;
          end else begin
            out_data_nxt.out_month = {4'd0, cur_month_r};
            out_data_nxt.out_day   = {5'd0, cur_day_r};
            out_data_nxt.out_year  = cur_year_r;
            out_data_nxt.not_past  = 1'b0;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and calendar registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= 16'sd0;
      day_len_r   <= 15'd0;
      cur_month_r <= tcdr_pkg::RESET_MONTH;
      cur_day_r   <= tcdr_pkg::RESET_DAY;
      cur_year_r  <= EPOCH_YEAR;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      day_len_r   <= day_len_nxt;
      cur_month_r <= cur_month_nxt;
      cur_day_r   <= cur_day_nxt;
      cur_year_r  <= cur_year_nxt;
    end
  end

  // working and payload registers, no reset needed
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    rolled_r   <= rolled_nxt;
    wm_r       <= wm_nxt;
    wd_r       <= wd_nxt;
    wy_r       <= wy_nxt;
    leap_r     <= leap_nxt;
    secs_r     <= secs_nxt;
    nd_r       <= nd_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // current date always names a real month
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_month_r >= 4'd1) && (cur_month_r <= tcdr_pkg::MONTHS_PER_YEAR))
    else $error("current month out of range");

  // day length never passes the saturated rate
  a_day_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    day_len_r <= 15'd32760)
    else $error("day length above saturation limit");

  // division only runs against a nonzero old day length
  a_div_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (day_len_r != 15'd0))
    else $error("rescale divide with zero divisor");

  // a day roll and a resolve flag never come from the same transaction
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.rolled_over && out_data_r.not_past))
    else $error("rolled_over and not_past both set");

endmodule

>>> rtl/tcdr_alu.sv
// shared add/subtract unit used by the tick, month, day and divide steps of the sequencer
module tcdr_alu (
  input  tcdr_pkg::alu_req_t req,
  output tcdr_pkg::alu_rsp_t rsp
);

  logic [tcdr_pkg::ALU_W:0] sum;

  assign sum = {1'b0, req.a}
             + {1'b0, (req.sub ? ~req.b : req.b)}
             + {{tcdr_pkg::ALU_W{1'b0}}, req.sub};

  assign rsp.res  = sum[tcdr_pkg::ALU_W-1:0];
  assign rsp.cout = sum[tcdr_pkg::ALU_W];

endmodule

>>> dv/tcdr_calendar_checker.sv
// checker for the tick calendar: follows both channels, works out each result and compares it
module tcdr_calendar_checker
  import tcdr_pkg::*;
#(
  parameter logic [15:0] EPOCH_YEAR = 16'd2155
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        results_seen,
  output int        rolls_seen,
  output int        not_past_seen
);

  localparam int unsigned TICKS_PER_SECOND = 24;
  localparam int unsigned MONTHS           = 12;
  localparam int unsigned FEBRUARY         = 2;
  localparam int          REPORT_LIMIT     = 10;
  localparam int unsigned COUNTER_CAP      = 32767;

  // own copy of the calendar
  logic signed [15:0] cal_counter;
  logic [15:0]        cal_day_len;
  logic [3:0]         cal_month;
  logic [4:0]         cal_day;
  logic [15:0]        cal_year;

  out_item_t calendar_outcomes[$];
  int        mismatches;
  int        n_results;
  int        n_rolls;
  int        n_not_past;

  function automatic bit leap_year(input logic [15:0] y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // month numbers outside 1..12 count as long months
  function automatic int unsigned days_in(input int unsigned m, input logic [15:0] y);
    case (m)
      FEBRUARY:     return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:  return 30;
      default:      return 31;
    endcase
  endfunction

  task automatic calendar_step(input in_item_t it, output out_item_t r);
    int unsigned m;
    int unsigned d;
    int unsigned secs;
    int unsigned new_len;
    int unsigned new_count;
    int unsigned count_u;
    logic [15:0] y;
    r = '0;
    case (it.mode)
      MODE_TICK: begin
        cal_counter = cal_counter - 16'sd1;
        if (cal_counter <= 16'sd0) begin
          cal_counter = signed'(cal_day_len);
          if (cal_day_len != 16'd0) begin
            r.rolled_over = 1'b1;
            d = cal_day + 1;
            m = cal_month;
            y = cal_year;
            if (d > days_in(m, y)) begin
              d = 1;
              m++;
              if (m > MONTHS) begin
                m = 1;
                y++;
              end
            end
            cal_day   = d[4:0];
            cal_month = m[3:0];
            cal_year  = y;
          end
        end
        r.out_month = 8'(cal_month);
        r.out_day   = 10'(cal_day);
        r.out_year  = cal_year;
      end
      MODE_RESOLVE: begin
        m = it.month_field;
        d = it.day_field;
        y = it.year_field;
        if (it.is_relative) begin
          m = m + cal_month - 1;
          y = it.year_field + cal_year + 16'(m / MONTHS);
          m = m % MONTHS + 1;
          d = d + cal_day;
          // walk the day offset forward one month at a time
          while (d > days_in(m, y)) begin
            d -= days_in(m, y);
            m++;
            if (m > MONTHS) begin
              m = 1;
              y++;
            end
          end
        end
        if (y > cal_year) begin
          r.not_past = 1'b1;
        end else if (y == cal_year) begin
          r.not_past = (m > cal_month) || ((m == cal_month) && (d >= cal_day));
        end
        r.out_month = m[7:0];
        r.out_day   = d[9:0];
        r.out_year  = y;
      end
      MODE_RATE: begin
        secs = it.day_seconds;
        if (secs > MAX_SECONDS) secs = MAX_SECONDS;
        new_len = secs * TICKS_PER_SECOND;
        if (cal_day_len == 16'd0) begin
          new_count = new_len;
        end else if (cal_counter <= 16'sd0) begin
          new_count = 0;
        end else begin
          count_u   = 32'(unsigned'(cal_counter));
          new_count = count_u * new_len / cal_day_len;
          if (new_count == 0) new_count = 1;
          if (new_count > COUNTER_CAP) new_count = COUNTER_CAP;
        end
        cal_day_len = new_len[15:0];
        cal_counter = signed'(new_count[15:0]);
        r.out_month = 8'(cal_month);
        r.out_day   = 10'(cal_day);
        r.out_year  = cal_year;
      end
      default: begin
        r.out_month = 8'(cal_month);
        r.out_day   = 10'(cal_day);
        r.out_year  = cal_year;
      end
    endcase
    r.ticks_left = cal_counter;
  endtask

  function automatic void check_field(input string what, input logic signed [31:0] want_v,
                                      input logic signed [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("mismatch in %s of result %0d: expected %0d, got %0d",
                 what, n_results, want_v, got_v);
      end
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      cal_counter = '0;
      cal_day_len = '0;
      cal_month   = RESET_MONTH;
      cal_day     = RESET_DAY;
      cal_year    = EPOCH_YEAR;
      calendar_outcomes.delete();
    end else begin
      // results first: nothing taken at this edge can already have its result
      if (out_valid && !out_stall) begin
        n_results++;
        if (out_data.rolled_over === 1'b1) n_rolls++;
        if (out_data.not_past === 1'b1) n_not_past++;
        if (calendar_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result %0d arrived with no transaction waiting for it", n_results);
          end
        end else begin
          want = calendar_outcomes.pop_front();
          check_field("rolled_over", 32'(want.rolled_over), 32'(out_data.rolled_over));
          check_field("out_month", 32'(want.out_month), 32'(out_data.out_month));
          check_field("out_day", 32'(want.out_day), 32'(out_data.out_day));
          check_field("out_year", 32'(want.out_year), 32'(out_data.out_year));
          check_field("not_past", 32'(want.not_past), 32'(out_data.not_past));
          check_field("ticks_left", 32'(want.ticks_left), 32'(out_data.ticks_left));
        end
      end
      if (in_valid && !in_stall) begin
        calendar_step(in_data, want);
        calendar_outcomes.push_back(want);
      end
    end
    fail_count    <= mismatches;
    pending       <= calendar_outcomes.size();
    results_seen  <= n_results;
    rolls_seen    <= n_rolls;
    not_past_seen <= n_not_past;
  end

endmodule

>>> dv/tb.sv
// testbench top for the tick calendar: stimulus, idling, hold-off and the verdict
module tb;
  import tcdr_pkg::*;

  localparam logic [15:0] EPOCH_YEAR      = 16'd2155;
  localparam logic [1:0]  MODE_UNUSED     = 2'd3;
  localparam int          ITEMS_PER_STAGE = 280;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          HOLD_AT_ITEM    = 20;
  localparam int          SETTLE_CYCLES   = 100;
  localparam int          CYCLE_LIMIT     = 400000;
  localparam int          STAGES          = 3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  // idle rates in percent; the receiver's is read at the clock edge so it moves by nba
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  // long hold-off: the sender asks, the receiver counts it down on its own
  int hold_asks   = 0;
  int hold_served = 0;
  int hold_left   = 0;

  int fail_count;
  int pending;
  int results_seen;
  int rolls_seen;
  int not_past_seen;

  tick_calendar_with_date_resolve_top #(
    .EPOCH_YEAR(EPOCH_YEAR)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  tcdr_calendar_checker #(
    .EPOCH_YEAR(EPOCH_YEAR)
  ) calendar_watch (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .rolls_seen   (rolls_seen),
    .not_past_seen(not_past_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // result side: a pending hold-off wins, otherwise stall at the current idle rate
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_CYCLES - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= (int'($urandom_range(99)) < rx_idle_pct);
    end
  end

  function automatic in_item_t calendar_item(input logic [1:0] mode, input logic rel,
                                             input logic [7:0] month, input logic [9:0] day,
                                             input logic [15:0] year, input logic [10:0] secs);
    in_item_t it;
    it.mode        = mode;
    it.is_relative = rel;
    it.month_field = month;
    it.day_field   = day;
    it.year_field  = year;
    it.day_seconds = secs;
    return it;
  endfunction

  // mostly ticks at a short day so the date really moves; every field random underneath
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned form;
    it.mode        = MODE_TICK;
    it.is_relative = 1'($urandom_range(1));
    it.month_field = 8'($urandom_range(255));
    it.day_field   = 10'($urandom_range(1023));
    it.year_field  = 16'($urandom);
    it.day_seconds = 11'($urandom_range(2047));
    pick = $urandom_range(99);
    form = $urandom_range(99);
    if (pick < 58) begin
      it.mode = MODE_TICK;
    end else if (pick < 82) begin
      it.mode = MODE_RESOLVE;
      if (it.is_relative && form < 50) begin
        // short offsets, landing close to today
        it.month_field = 8'($urandom_range(15));
        it.day_field   = 10'($urandom_range(62));
        it.year_field  = 16'($urandom_range(3));
      end else if (!it.is_relative && form < 60) begin
        // absolute dates around today so the year and month compare ties often
        it.month_field = 8'($urandom_range(4, 1));
        it.day_field   = 10'($urandom_range(31));
        it.year_field  = EPOCH_YEAR - 16'd1 + 16'($urandom_range(2));
      end
    end else if (pick < 95) begin
      it.mode = MODE_RATE;
      if (form < 70) begin
        it.day_seconds = 11'($urandom_range(2, 1));
      end else if (form < 80) begin
        it.day_seconds = '0;
      end else if (form < 88) begin
        it.day_seconds = 11'($urandom_range(2047, 1366));
      end
    end else begin
      it.mode = MODE_UNUSED;
    end
    return it;
  endfunction

  // present one transaction, after a random gap, and hold it until taken
  task automatic offer(input in_item_t item);
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // sender pauses until every transaction so far has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: halted clock, spare mode and field extremes
    offer(calendar_item(MODE_TICK, 1'b0, 8'd0, 10'd0, 16'd0, 11'd0));
    offer(calendar_item(MODE_UNUSED, 1'b1, 8'hff, 10'h3ff, 16'hffff, 11'h7ff));
    // absolute resolve: today, the day before, a later and an earlier month
    offer(calendar_item(MODE_RESOLVE, 1'b0, 8'd2, 10'd17, EPOCH_YEAR, 11'd0));
    offer(calendar_item(MODE_RESOLVE, 1'b0, 8'd2, 10'd16, EPOCH_YEAR, 11'd0));
    offer(calendar_item(MODE_RESOLVE, 1'b0, 8'd3, 10'd1, EPOCH_YEAR, 11'd0));
    offer(calendar_item(MODE_RESOLVE, 1'b0, 8'd1, 10'd31, EPOCH_YEAR, 11'd0));
    // absolute fields taken as they stand, all zero and all ones
    offer(calendar_item(MODE_RESOLVE, 1'b0, 8'd0, 10'd0, 16'd0, 11'd0));
    offer(calendar_item(MODE_RESOLVE, 1'b0, 8'hff, 10'h3ff, 16'hffff, 11'd0));
    // relative: no offset, largest offsets
    offer(calendar_item(MODE_RESOLVE, 1'b1, 8'd0, 10'd0, 16'd0, 11'd0));
    offer(calendar_item(MODE_RESOLVE, 1'b1, 8'hff, 10'h3ff, 16'hffff, 11'd0));
    // relative into a leap february, a century non-leap and a 400-year leap
    offer(calendar_item(MODE_RESOLVE, 1'b1, 8'd0, 10'd12, 16'd1, 11'd0));
    offer(calendar_item(MODE_RESOLVE, 1'b1, 8'd0, 10'd12, 16'd45, 11'd0));
    offer(calendar_item(MODE_RESOLVE, 1'b1, 8'd0, 10'd12, 16'd245, 11'd0));
    // year wraps round to zero, which is a leap year
    offer(calendar_item(MODE_RESOLVE, 1'b1, 8'd0, 10'd12, 16'd63381, 11'd0));
    // rate: zero while halted, then saturated
    offer(calendar_item(MODE_RATE, 1'b0, 8'd0, 10'd0, 16'd0, 11'd0));
    offer(calendar_item(MODE_RATE, 1'b0, 8'd0, 10'd0, 16'd0, 11'h7ff));
    offer(calendar_item(MODE_TICK, 1'b0, 8'd0, 10'd0, 16'd0, 11'd0));
    // rescale down, back up to the ceiling, then to zero which leaves one tick
    offer(calendar_item(MODE_RATE, 1'b0, 8'd0, 10'd0, 16'd0, 11'd1));
    offer(calendar_item(MODE_RATE, 1'b0, 8'd0, 10'd0, 16'd0, MAX_SECONDS));
    offer(calendar_item(MODE_RATE, 1'b0, 8'd0, 10'd0, 16'd0, 11'd0));
    offer(calendar_item(MODE_TICK, 1'b0, 8'd0, 10'd0, 16'd0, 11'd0));
    offer(calendar_item(MODE_TICK, 1'b0, 8'd0, 10'd0, 16'd0, 11'd0));
    // shortest day, so the random part rolls the date
    offer(calendar_item(MODE_RATE, 1'b0, 8'd0, 10'd0, 16'd0, 11'd1));
    wait_drained();

    // random: sender idles little and receiver much, then swapped, then no idling
    for (int stage = 0; stage < STAGES; stage++) begin
      case (stage)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct <= 78;
        end
        1: begin
          tx_idle_pct = 78;
          rx_idle_pct <= 15;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_STAGE; n++) begin
        // long hold-off with the sender still offering, so the block backs up
        if (stage == STAGES - 1 && n == HOLD_AT_ITEM) hold_asks <= hold_asks + 1;
        offer(random_item());
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d transactions over ticks, date resolves and rate changes", results_seen);
    $display("  %0d day roll-overs, %0d resolves not in the past", rolls_seen, not_past_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tcdr_pkg.sv
rtl/tcdr_alu.sv
rtl/tick_calendar_with_date_resolve_top.sv
dv/tcdr_calendar_checker.sv
dv/tb.sv
